[rtl/tt_pkg.sv]
// Package for the transposition table: table geometry, operation and bound codes,
// and the entry, request and result types.
// No dependencies.
package tt_pkg;

    localparam int ENTRIES = 2048;
    localparam int IDX_W   = $clog2(ENTRIES);

    localparam logic [14:0] MATE_BOUND_RST = 15'd31000;

    localparam logic [2:0] OP_READ    = 3'd0;
    localparam logic [2:0] OP_PROBE   = 3'd1;
    localparam logic [2:0] OP_WRITE   = 3'd2;
    localparam logic [2:0] OP_NEW_AGE = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    localparam logic [1:0] KIND_EXACT = 2'd0;
    localparam logic [1:0] KIND_UPPER = 2'd1;
    localparam logic [1:0] KIND_LOWER = 2'd2;

    typedef struct packed {
        logic [63:0]        key;
        logic [15:0]        move;
        logic signed [15:0] score;
        logic signed [7:0]  depth;
        logic [1:0]         kind;
        logic [7:0]         age;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [2:0]         op;
        logic [63:0]        key;
        logic signed [7:0]  depth;
        logic [6:0]         ply;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        logic [15:0]        new_move;
        logic signed [15:0] new_score;
        logic [1:0]         kind;
    } t_req;

    typedef struct packed {
        logic               usable;
        logic               matched;
        logic [15:0]        move;
        logic signed [15:0] score;
    } t_result;

endpackage

[rtl/tt_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module tt_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 114
) (
    input  logic                     i_clk,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

endmodule

[rtl/tt_eval.sv]
// Evaluates one request against the entry read from the table: hit test, mate
// adjustment, cutoff test and the replacement decision. Depends on tt_pkg.
module tt_eval
    import tt_pkg::*;
(
    input  t_req        i_req,
    input  t_entry      i_entry,
    input  logic [7:0]  i_age,
    input  logic [14:0] i_mate_bound,
    output t_result     o_res,
    output logic        o_wr_en,
    output t_entry      o_wr_entry
);

    localparam logic signed [17:0] SAT_HI = 18'sd32767;
    localparam logic signed [17:0] SAT_LO = -18'sd32768;

    logic               matched;
    logic               depth_ok;
    logic               kind_ok;
    logic signed [17:0] s_ext;
    logic signed [17:0] mb_ext;
    logic signed [17:0] ply_ext;
    logic signed [17:0] adj;
    logic signed [15:0] score;

    always_comb begin
        matched  = (i_entry.key == i_req.key);
        depth_ok = (i_entry.depth >= i_req.depth);

        // mate scores drift toward zero by ply; a probe reads at ply zero
        s_ext   = 18'(i_entry.score);
        mb_ext  = {3'b000, i_mate_bound};
        ply_ext = (i_req.op == OP_PROBE) ? 18'sd0 : {11'b0, i_req.ply};
        if (s_ext >= mb_ext) begin
            adj = s_ext - ply_ext;
        end else if (s_ext <= -mb_ext) begin
            adj = s_ext + ply_ext;
        end else begin
            adj = s_ext;
        end
        if (adj > SAT_HI) begin
            score = 16'sh7FFF;
        end else if (adj < SAT_LO) begin
            score = 16'sh8000;
        end else begin
            score = adj[15:0];
        end

        case (i_entry.kind)
            KIND_EXACT: kind_ok = 1'b1;
            KIND_UPPER: kind_ok = (score <= i_req.alpha);
            KIND_LOWER: kind_ok = (score >= i_req.beta);
            default:    kind_ok = 1'b0;
        endcase

        o_res   = '0;
        o_wr_en = 1'b0;
        unique case (i_req.op)
            OP_READ: begin
                if (matched) begin
                    o_res.matched = 1'b1;
                    o_res.move    = i_entry.move;
                    if (depth_ok && kind_ok) begin
                        o_res.usable = 1'b1;
                        o_res.score  = score;
                    end
                end
            end
            OP_PROBE: begin
                if (matched) begin
                    o_res.matched = 1'b1;
                    o_res.usable  = 1'b1;
                    o_res.move    = i_entry.move;
                    o_res.score   = score;
                end
            end
            OP_WRITE: begin
                o_wr_en = (i_entry.key == 64'd0) || matched ||
                          (i_req.depth >= i_entry.depth) || (i_entry.age != i_age);
            end
            default: begin
            end
        endcase

        o_wr_entry.key   = i_req.key;
        o_wr_entry.move  = (i_req.new_move != 16'd0) ? i_req.new_move : i_entry.move;
        o_wr_entry.score = i_req.new_score;
        o_wr_entry.depth = i_req.depth;
        o_wr_entry.kind  = i_req.kind;
        o_wr_entry.age   = i_age;
    end

endmodule

[rtl/search_transposition_table.sv]
// Channel | handshake                | payload
// --------+--------------------------+------------------------------------------
// in      | i_in_valid / o_in_ready  | operation, key, depth, ply, window, move,
//         |                          | score, bound kind
// out     | o_out_valid / i_out_ready| usable, key_matched, found_move, found_score
// cfg     | i_cfg_we                 | i_cfg_wdata (mate bound)
//
// Each item is handled as a table read at acceptance, then evaluation and
// write-back from the registered read data. One item is in flight at a time.
// After reset and after a clear item, a sweep zeroes all 2048 entries, one per
// cycle; no item is taken meanwhile, config writes still are.
// A result waiting in the output register stalls evaluation of the next item.
// Top level of the transposition table; depends on tt_pkg, tt_ram and tt_eval.
module search_transposition_table
    import tt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [14:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_operation,
    input  logic [63:0]        i_position_key,
    input  logic signed [7:0]  i_search_depth,
    input  logic [6:0]         i_ply_from_root,
    input  logic signed [15:0] i_alpha_bound,
    input  logic signed [15:0] i_beta_bound,
    input  logic [15:0]        i_new_move,
    input  logic signed [15:0] i_new_score,
    input  logic [1:0]         i_bound_kind,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_usable,
    output logic               o_key_matched,
    output logic [15:0]        o_found_move,
    output logic signed [15:0] o_found_score
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EVAL  = 2'd2;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [IDX_W-1:0]   r_clr_idx;
    logic [7:0]         r_age;
    logic [14:0]        r_mate_bound;
    t_req               r_req;
    logic               r_out_valid;
    t_result            r_res;

    logic               accept;
    logic               out_free;
    logic               finish;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    t_entry             ram_wdata;
    t_result            eval_res;
    logic               eval_wr_en;
    t_entry             eval_wr_entry;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign finish     = (r_state == S_EVAL) && out_free;

    tt_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_re    (accept),
        .i_raddr (i_position_key[IDX_W-1:0]),
        .o_rdata (ram_rdata),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata)
    );

    tt_eval u_eval (
        .i_req        (r_req),
        .i_entry      (t_entry'(ram_rdata)),
        .i_age        (r_age),
        .i_mate_bound (r_mate_bound),
        .o_res        (eval_res),
        .o_wr_en      (eval_wr_en),
        .o_wr_entry   (eval_wr_entry)
    );

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_clr_idx;
        ram_wdata = '0;
        if (r_state == S_CLEAR) begin
            ram_we = 1'b1;
        end else if (finish && eval_wr_en) begin
            ram_we    = 1'b1;
            ram_waddr = r_req.key[IDX_W-1:0];
            ram_wdata = eval_wr_entry;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == IDX_W'(ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (out_free) begin
                    n_state = (r_req.op == OP_CLEAR) ? S_CLEAR : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_idx    <= '0;
            r_age        <= '0;
            r_mate_bound <= MATE_BOUND_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_mate_bound <= i_cfg_wdata;
            end
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
                if (r_req.op == OP_NEW_AGE) begin
                    r_age <= r_age + 8'd1;
                end else if (r_req.op == OP_CLEAR) begin
                    r_age     <= '0;
                    r_clr_idx <= '0;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.op        <= i_operation;
            r_req.key       <= i_position_key;
            r_req.depth     <= i_search_depth;
            r_req.ply       <= i_ply_from_root;
            r_req.alpha     <= i_alpha_bound;
            r_req.beta      <= i_beta_bound;
            r_req.new_move  <= i_new_move;
            r_req.new_score <= i_new_score;
            r_req.kind      <= i_bound_kind;
        end
        if (finish) begin
            r_res <= eval_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_usable      = r_res.usable;
    assign o_key_matched = r_res.matched;
    assign o_found_move  = r_res.move;
    assign o_found_score = r_res.score;

endmodule

[rtl/tt_checker.sv]
// Port-level checks for the transposition table, bound to the top level.
// Depends on search_transposition_table.
module tt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic               o_usable,
    input logic               o_key_matched,
    input logic [15:0]        o_found_move,
    input logic signed [15:0] o_found_score
);

    // no move and no usable score without a key hit
    a_miss_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_key_matched) |-> (!o_usable && o_found_move == 16'd0))
        else $error("result on a miss carries data");

    a_score_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_usable) |-> (o_found_score == 16'sd0))
        else $error("score given without usable");

    // one item at a time: input closes right after an item is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while one is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_found_move) && $stable(o_found_score)))
        else $error("stalled result changed");

endmodule

bind search_transposition_table tt_checker u_tt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_usable      (o_usable),
    .o_key_matched (o_key_matched),
    .o_found_move  (o_found_move),
    .o_found_score (o_found_score)
);
